>>> rtl/core/ppmfd_pkg.sv
package ppmfd_pkg;

	localparam int CHANNELS = 10;

	localparam int TIME_W  = 32;
	localparam int WIDTH_W = 16;
	localparam int CHIDX_W = 4;
	localparam int CNT_W   = $clog2(CHANNELS + 1);
	localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int REG_W   = 16;
	localparam int RIDX_W  = 2;
	localparam int OUT_W   = ((CHIDX_W + WIDTH_W + 7) / 8) * 8;

	// register indexes on the configuration port
	localparam logic [RIDX_W-1:0] REG_MIN_WIDTH  = 2'd0;
	localparam logic [RIDX_W-1:0] REG_MAX_WIDTH  = 2'd1;
	localparam logic [RIDX_W-1:0] REG_RESYNC_GAP = 2'd2;
	localparam logic [RIDX_W-1:0] REG_START_GAP  = 2'd3;

	localparam logic [REG_W-1:0] MIN_WIDTH_RST  = 16'd800;
	localparam logic [REG_W-1:0] MAX_WIDTH_RST  = 16'd2200;
	localparam logic [REG_W-1:0] RESYNC_GAP_RST = 16'd3000;
	localparam logic [REG_W-1:0] START_GAP_RST  = 16'd2500;

	typedef struct packed {
		logic load;
		logic store;
		logic clear_count;
		logic emit_start;
		logic emit_load;
	} ppmfd_cmd_t;

	typedef struct packed {
		logic in_window;
		logic ge_resync;
		logic ge_start;
		logic count_full;
		logic count_last;
		logic rd_last;
		logic out_free;
	} ppmfd_sts_t;

endpackage

>>> rtl/core/ppmfd_datapath.sv
module ppmfd_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ppmfd_pkg::RIDX_W-1:0]    cfg_index,
	input  logic [ppmfd_pkg::REG_W-1:0]     cfg_data,
	input  logic [ppmfd_pkg::TIME_W-1:0]    edge_time,
	input  ppmfd_pkg::ppmfd_cmd_t           cmd,
	output ppmfd_pkg::ppmfd_sts_t           sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [ppmfd_pkg::CHIDX_W-1:0]   out_index,
	output logic [ppmfd_pkg::WIDTH_W-1:0]   out_width,
	output logic                            out_last
);
	import ppmfd_pkg::*;

	logic [REG_W-1:0]   min_width_q;
	logic [REG_W-1:0]   max_width_q;
	logic [REG_W-1:0]   resync_gap_q;
	logic [REG_W-1:0]   start_gap_q;
	logic [TIME_W-1:0]  prev_time_q;
	logic [TIME_W-1:0]  delta_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   rd_q;
	logic [WIDTH_W-1:0] store_q [CHANNELS];
	logic               out_valid_q;
	logic [CHIDX_W-1:0] out_index_q;
	logic [WIDTH_W-1:0] out_width_q;
	logic               out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_width_q  <= MIN_WIDTH_RST;
			max_width_q  <= MAX_WIDTH_RST;
			resync_gap_q <= RESYNC_GAP_RST;
			start_gap_q  <= START_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_WIDTH:  min_width_q  <= cfg_data;
				REG_MAX_WIDTH:  max_width_q  <= cfg_data;
				REG_RESYNC_GAP: resync_gap_q <= cfg_data;
				REG_START_GAP:  start_gap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// interval modulo 2^32 from the previous edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
		end else if (cmd.load) begin
			prev_time_q <= edge_time;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			delta_q <= edge_time - prev_time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear_count) begin
			count_q <= '0;
		end else if (cmd.store) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_q[count_q[IDX_W-1:0]] <= delta_q[WIDTH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
		end else if (cmd.emit_start) begin
			rd_q <= '0;
		end else if (cmd.emit_load) begin
			rd_q <= rd_q + IDX_W'(1);
		end
	end

	// output register, refilled in the cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_index_q <= CHIDX_W'(rd_q);
			out_width_q <= store_q[rd_q];
			out_last_q  <= sts.rd_last;
		end
	end

	always_comb begin
		sts.in_window  = (delta_q >= TIME_W'(min_width_q)) && (delta_q <= TIME_W'(max_width_q));
		sts.ge_resync  = delta_q >= TIME_W'(resync_gap_q);
		sts.ge_start   = delta_q >= TIME_W'(start_gap_q);
		sts.count_full = count_q >= CNT_W'(CHANNELS);
		sts.count_last = count_q == CNT_W'(CHANNELS - 1);
		sts.rd_last    = rd_q == IDX_W'(CHANNELS - 1);
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_width = out_width_q;
	assign out_last  = out_last_q;

endmodule

>>> rtl/core/ppmfd_ctrl.sv
module ppmfd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ppmfd_pkg::ppmfd_sts_t sts,
	output ppmfd_pkg::ppmfd_cmd_t cmd
);
	import ppmfd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       in_sync_q;
	logic       in_sync_d;

	always_comb begin
		state_d   = state_q;
		in_sync_d = in_sync_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_IDLE;
				if (in_sync_q) begin
					if (sts.in_window) begin
						// a full count in sync cannot arise; the interval is ignored then
						if (!sts.count_full) begin
							cmd.store = 1'b1;
							if (sts.count_last) begin
								cmd.emit_start = 1'b1;
								in_sync_d      = 1'b0;
								state_d        = ST_EMIT;
							end
						end
					end else if (sts.ge_resync) begin
						cmd.clear_count = 1'b1;
					end else begin
						in_sync_d = 1'b0;
					end
				end else if (sts.ge_start) begin
					in_sync_d       = 1'b1;
					cmd.clear_count = 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (sts.rd_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			in_sync_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			in_sync_q <= in_sync_d;
		end
	end

endmodule

>>> rtl/core/ppm_frame_decoder_top.sv
// PPM frame decoder. Each input item is the microsecond timestamp of one edge;
// the interval to the previous edge (modulo 2^32) drives sync, channel capture
// and frame restart. For each edge the interval is registered first, then the
// controller decides on it, and the input is ready again after that. The edge
// that completes a frame also starts a burst of CHANNELS output items, one per
// cycle from the channel store while the output is taken, with tlast on the
// final channel; the input stays closed for the whole burst, including any
// output stall, and the last item may still wait in the output register while
// the next edge is taken. Configuration writes take effect at once and are meant
// for when no edge is in flight.
module ppm_frame_decoder_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ppmfd_pkg::RIDX_W-1:0]       cfg_index,
	input  logic [ppmfd_pkg::REG_W-1:0]        cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [ppmfd_pkg::TIME_W-1:0]       s_axis_tdata,  // edge_time_us
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [ppmfd_pkg::OUT_W-1:0]        m_axis_tdata,  // channel_index, pulse_width, zero pad
	output logic                               m_axis_tlast   // frame_last
);
	import ppmfd_pkg::*;

	ppmfd_cmd_t         cmd;
	ppmfd_sts_t         sts;
	logic [CHIDX_W-1:0] channel_index;
	logic [WIDTH_W-1:0] pulse_width;

	ppmfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ppmfd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.edge_time (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_index (channel_index),
		.out_width (pulse_width),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_W'({pulse_width, channel_index});

endmodule

>>> rtl/core/ppmfd_checker.sv
module ppmfd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [ppmfd_pkg::OUT_W-1:0]  m_axis_tdata,
	input logic                         m_axis_tlast
);
	import ppmfd_pkg::*;

	// a stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[CHIDX_W-1:0] == CHIDX_W'(CHANNELS - 1))
		else $error("tlast on a channel other than the final one");

	// a frame goes out as an unbroken run of rising channel numbers
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid
			&& m_axis_tdata[CHIDX_W-1:0] == $past(m_axis_tdata[CHIDX_W-1:0]) + CHIDX_W'(1))
		else $error("frame burst broken or out of order");

	// no edge is taken while a frame is still being read out
	a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready during frame readout");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1:CHIDX_W+WIDTH_W] == '0)
		else $error("tdata padding not zero");

endmodule

bind ppm_frame_decoder_top ppmfd_checker u_ppmfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
